// File: design/irpwnd_pkg.sv
package irpwnd_pkg;

  localparam int WORD_BITS  = 4;
  localparam int TIME_WIDTH = 16;
  localparam int CNT_WIDTH  = 14;
  localparam int IDX_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CNT_WIDTH-1:0]  count_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [IDX_W-1:0]      idx_t;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_GUIDE_MIN     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GUIDE_MAX     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MIN      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_LIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_CAP   = 3'd5;

  localparam time_t  GUIDE_MIN_RST     = TIME_WIDTH'(900);
  localparam time_t  GUIDE_MAX_RST     = TIME_WIDTH'(1100);
  localparam time_t  ONE_MIN_RST       = TIME_WIDTH'(500);
  localparam time_t  ZERO_MIN_RST      = TIME_WIDTH'(100);
  localparam count_t SILENCE_LIMIT_RST = CNT_WIDTH'(200);
  localparam count_t SILENCE_CAP_RST   = CNT_WIDTH'(10000);

  localparam word_t  LOST_CODE = WORD_BITS'(3);
  localparam idx_t   IDX_MSB   = IDX_W'(WORD_BITS - 1);

  typedef struct packed {
    time_t guide_min;
    time_t guide_max;
    time_t one_min;
    time_t zero_min;
  } thresholds_t;

  typedef enum logic [1:0] {
    PULSE_NONE  = 2'd0,
    PULSE_GUIDE = 2'd1,
    PULSE_ONE   = 2'd2,
    PULSE_ZERO  = 2'd3
  } pulse_kind_t;

  typedef struct packed {
    word_t code;
    logic  signal_lost;
  } result_t;

endpackage

// File: design/irpwnd_classify.sv
module irpwnd_classify (
  input  irpwnd_pkg::time_t       high_time,
  input  irpwnd_pkg::thresholds_t thr,
  output irpwnd_pkg::pulse_kind_t kind
);
  import irpwnd_pkg::*;

  logic is_guide, is_one, is_zero;

  // bounds used exactly as written; guide wins over the bit ranges
  assign is_guide = (high_time >= thr.guide_min) && (high_time <= thr.guide_max);
  assign is_one   = (high_time >= thr.one_min)   && (high_time <  thr.guide_min);
  assign is_zero  = (high_time >= thr.zero_min)  && (high_time <  thr.one_min);

  always_comb begin
    if (is_guide) begin
      kind = PULSE_GUIDE;
    end else if (is_one) begin
      kind = PULSE_ONE;
    end else if (is_zero) begin
      kind = PULSE_ZERO;
    end else begin
      kind = PULSE_NONE;
    end
  end

endmodule

// File: design/ir_pulse_width_nibble_decoder_core.sv
// Channel   Dir  Beat contents (lowest bit first)
// in_*      in   tdata: line_idle[0], high_time[16:1]; tuser: capture_valid
// out_*     out  tdata: code[3:0], signal_lost[4]
// cfg_*     in   write only: cfg_addr selects register, cfg_wdata its value
//
// One poll beat per cycle while in_tready is high: the decode is a single pass
// of compares and small register updates between the input port and the result
// register. A two-deep output buffer (result register plus skid register) lets
// in_tready stay high while one result waits. rst_n is synchronous, active low;
// decoder state and thresholds return to their defaults. in_tready drops only
// while both output slots are full.
module ir_pulse_width_nibble_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // line_idle, high_time, pad
  input  logic                              in_tuser,   // capture_valid
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // code, signal_lost, pad
  input  logic                              cfg_we,
  input  logic [irpwnd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [irpwnd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irpwnd_pkg::*;

  // ---------------- configuration registers ----------------
  thresholds_t thr_r;
  count_t      limit_r;
  count_t      cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.guide_min <= GUIDE_MIN_RST;
      thr_r.guide_max <= GUIDE_MAX_RST;
      thr_r.one_min   <= ONE_MIN_RST;
      thr_r.zero_min  <= ZERO_MIN_RST;
      limit_r         <= SILENCE_LIMIT_RST;
      cap_r           <= SILENCE_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GUIDE_MIN:     thr_r.guide_min <= TIME_WIDTH'(cfg_wdata);
        REG_GUIDE_MAX:     thr_r.guide_max <= TIME_WIDTH'(cfg_wdata);
        REG_ONE_MIN:       thr_r.one_min   <= TIME_WIDTH'(cfg_wdata);
        REG_ZERO_MIN:      thr_r.zero_min  <= TIME_WIDTH'(cfg_wdata);
        REG_SILENCE_LIMIT: limit_r         <= cfg_wdata[CNT_WIDTH-1:0];
        REG_SILENCE_CAP:   cap_r           <= cfg_wdata[CNT_WIDTH-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------- input beat unpacking ----------------
  logic  line_idle;
  logic  capture_valid;
  time_t high_time;
  logic  in_accept;

  assign line_idle     = in_tdata[0];
  assign high_time     = in_tdata[TIME_WIDTH:1];
  assign capture_valid = in_tuser;
  assign in_accept     = in_tvalid && in_tready;

  // ---------------- decoder state ----------------
  count_t cnt_r, cnt_nxt;
  logic   guide_r, guide_nxt;
  idx_t   idx_r, idx_nxt;
  word_t  asm_r, asm_nxt;
  word_t  last_r, last_nxt;
  logic   pend_r, pend_nxt;
  time_t  held_r, held_nxt;

  logic        pend_now;
  time_t       held_now;
  count_t      cnt_base;
  logic        lost;
  pulse_kind_t kind;
  word_t       bit_mask;
  word_t       asm_bit;
  result_t     res;

  // classifier looks at the held duration, which a fresh capture overrides
  assign pend_now = capture_valid | pend_r;
  assign held_now = capture_valid ? high_time : held_r;

  irpwnd_classify u_classify (
    .high_time (held_now),
    .thr       (thr_r),
    .kind      (kind)
  );

  assign bit_mask = WORD_BITS'(1) << idx_r;

  always_comb begin
    // silence counter: reload to limit at the cap, then count, 14-bit wrap
    cnt_base = (cnt_r >= cap_r) ? limit_r : cnt_r;
    cnt_nxt  = line_idle ? (cnt_base + CNT_WIDTH'(1)) : '0;
    lost     = (cnt_nxt >= limit_r);

    guide_nxt = guide_r;
    idx_nxt   = idx_r;
    asm_nxt   = asm_r;
    last_nxt  = last_r;
    pend_nxt  = pend_now;
    held_nxt  = held_now;
    asm_bit   = asm_r;

    if (!lost && pend_now) begin
      pend_nxt = 1'b0;
      if (kind == PULSE_GUIDE) begin
        guide_nxt = 1'b1;
        asm_nxt   = last_r;   // bit index deliberately left where it is
      end else if (guide_r) begin
        unique case (kind)
          PULSE_ONE:  asm_bit = asm_r | bit_mask;
          PULSE_ZERO: asm_bit = asm_r & ~bit_mask;
          default:    asm_bit = asm_r;  // out of range: slot still used up
        endcase
        asm_nxt = asm_bit;
        if (idx_r == '0) begin
          idx_nxt   = IDX_MSB;
          guide_nxt = 1'b0;
          last_nxt  = asm_bit;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
    end

    res.code        = lost ? LOST_CODE : last_nxt;
    res.signal_lost = lost;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      guide_r <= 1'b0;
      idx_r   <= IDX_MSB;
      asm_r   <= '0;
      last_r  <= '0;
      pend_r  <= 1'b0;
    end else if (in_accept) begin
      cnt_r   <= cnt_nxt;
      guide_r <= guide_nxt;
      idx_r   <= idx_nxt;
      asm_r   <= asm_nxt;
      last_r  <= last_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // held time only matters while pending is set, so no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_r <= held_nxt;
    end
  end

  // ---------------- output buffer: result register + skid ----------------
  logic    out_valid_r;
  result_t out_res_r;
  logic    skid_valid_r;
  result_t skid_res_r;
  logic    out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end
    if (!out_free && in_accept) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.signal_lost, out_res_r.code};

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held while result register empty");

  a_lost_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[WORD_BITS]) |-> (out_tdata[WORD_BITS-1:0] == LOST_CODE))
    else $error("signal lost reported with wrong code");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(idx_r) && $stable(last_r))
    else $error("decoder state moved without an input beat");

  a_lost_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && lost) |=> $stable(last_r))
    else $error("word updated during loss of signal");

endmodule

// File: tb/ir_pulse_width_nibble_decoder_core_test.sv
`timescale 1ns / 1ps

module ir_pulse_width_nibble_decoder_core_test;
  import irpwnd_pkg::*;

  // Scoreboard: tracks the decoder state on every accepted poll beat and
  // queues the code it should report, then checks result beats in order.
  class nibble_scoreboard;
    time_t  guide_min, guide_max, one_min, zero_min;
    count_t silence_limit, silence_cap;
    count_t silence_count;
    logic   guide_seen;
    idx_t   bit_index;
    word_t  assembling, last_word;
    logic   capture_held;
    time_t  held_time;
    result_t due_codes[$];
    int errors, nibbles, guides, lost_codes, checked;

    function new();
      guide_min     = GUIDE_MIN_RST;
      guide_max     = GUIDE_MAX_RST;
      one_min       = ONE_MIN_RST;
      zero_min      = ZERO_MIN_RST;
      silence_limit = SILENCE_LIMIT_RST;
      silence_cap   = SILENCE_CAP_RST;
      silence_count = '0;
      guide_seen    = 1'b0;
      bit_index     = IDX_MSB;
      assembling    = '0;
      last_word     = '0;
      capture_held  = 1'b0;
      held_time     = '0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        REG_GUIDE_MIN:     guide_min     = value;
        REG_GUIDE_MAX:     guide_max     = value;
        REG_ONE_MIN:       one_min       = value;
        REG_ZERO_MIN:      zero_min      = value;
        REG_SILENCE_LIMIT: silence_limit = count_t'(value);
        REG_SILENCE_CAP:   silence_cap   = count_t'(value);
        default: ;
      endcase
    endfunction

    function void predict_poll(logic idle, logic cap, time_t t);
      result_t r;
      pulse_kind_t kind;
      if (cap) begin
        capture_held = 1'b1;
        held_time    = t;
      end
      // silence counter: reload at the cap, then count, wrapping at 14 bits
      if (idle) begin
        if (silence_count >= silence_cap) silence_count = silence_limit;
        silence_count = silence_count + 1'b1;
      end else begin
        silence_count = '0;
      end
      if (silence_count >= silence_limit) begin
        // lost signal: capture stays held, last word untouched
        r.code        = LOST_CODE;
        r.signal_lost = 1'b1;
        lost_codes++;
      end else begin
        if (capture_held) begin
          capture_held = 1'b0;
          // guide test first; bounds taken as written, no reordering
          if (held_time >= guide_min && held_time <= guide_max)
            kind = PULSE_GUIDE;
          else if (held_time >= one_min && held_time < guide_min)
            kind = PULSE_ONE;
          else if (held_time >= zero_min && held_time < one_min)
            kind = PULSE_ZERO;
          else
            kind = PULSE_NONE;
          if (kind == PULSE_GUIDE) begin
            // mid-frame guide reloads the word but keeps the bit position
            guide_seen = 1'b1;
            assembling = last_word;
            guides++;
          end else if (guide_seen) begin
            if (kind == PULSE_ONE) assembling[bit_index] = 1'b1;
            else if (kind == PULSE_ZERO) assembling[bit_index] = 1'b0;
            // out-of-range pulse still spends its slot
            if (bit_index == '0) begin
              bit_index  = IDX_MSB;
              guide_seen = 1'b0;
              last_word  = assembling;
              nibbles++;
            end else begin
              bit_index--;
            end
          end
        end
        r.code        = last_word;
        r.signal_lost = 1'b0;
      end
      due_codes.push_back(r);
    endfunction

    function void check_code(word_t code, logic lost);
      result_t r;
      if (due_codes.size() == 0) begin
        $error("result beat with nothing due: code %0d signal_lost %0b", code, lost);
        errors++;
        return;
      end
      r = due_codes.pop_front();
      checked++;
      if (code !== r.code) begin
        $error("code: expected %0d, got %0d", r.code, code);
        errors++;
      end
      if (lost !== r.signal_lost) begin
        $error("signal_lost: expected %0b, got %0b", r.signal_lost, lost);
        errors++;
      end
    endfunction

    function int pending();
      return due_codes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // line_idle[0], high_time[16:1], pad
  logic                  in_tuser;   // capture_valid
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // code[3:0], signal_lost[4], pad
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nibble_scoreboard sb = new();

  int beats;        // poll beats accepted by the block
  int burst_left;   // beats left in the sender's current burst
  int settings;     // threshold sets applied after reset

  ir_pulse_width_nibble_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Both channels sampled on the rising edge, before the block updates.
  // The result check goes first: a result never leaves in its own beat's cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_code(out_tdata[3:0], out_tdata[4]);
      if (in_tvalid && in_tready) sb.predict_poll(in_tdata[0], in_tuser, in_tdata[16:1]);
    end
  end

  // Receiver: back-pressure in episodes of varying character, with a long
  // hold-off now and then so the output buffer fills and in_tready drops.
  initial begin : receiver
    int episode;
    int mode;
    int span;
    int k;
    out_tready = 1'b0;
    episode = 0;
    forever begin
      episode++;
      if (episode % 12 == 4) begin
        span = $urandom_range(40, 80);
        repeat (span) begin
          @(negedge clk);
          out_tready = 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        for (k = 0; k < span; k++) begin
          @(negedge clk);
          case (mode)
            0:       out_tready = 1'b1;                        // no stalls
            1:       out_tready = 1'($urandom_range(0, 1));
            2:       out_tready = ($urandom_range(0, 3) == 0); // mostly stalled
            default: out_tready = (k % 4 != 3);                // fixed rhythm
          endcase
        end
      end
    end
  end

  // One poll beat; opens a new burst with a random gap once the last one ends.
  task automatic send_beat(input logic idle, input logic cap, input time_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {7'b0, t, idle};
    in_tuser  = cap;
    do @(posedge clk); while (!in_tready);
    beats++;
  endtask

  // Drop valid and hold until every due result has been seen.
  task automatic settle();
    @(negedge clk);
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = CFG_DATA_W'(value);
    sb.set_reg(addr, CFG_DATA_W'(value));
  endtask

  task automatic apply_setting(input int gmin, input int gmax, input int one,
                               input int zero, input int lim, input int cap);
    settle();
    write_reg(REG_GUIDE_MIN, gmin);
    write_reg(REG_GUIDE_MAX, gmax);
    write_reg(REG_ONE_MIN, one);
    write_reg(REG_ZERO_MIN, zero);
    write_reg(REG_SILENCE_LIMIT, lim);
    write_reg(REG_SILENCE_CAP, cap);
    @(negedge clk);
    cfg_we = 1'b0;
    settings++;
  endtask

  // Duration inside [lo, hi]; any duration when the span is empty.
  function automatic time_t in_span(int lo, int hi);
    if (lo > hi || hi < 0) return time_t'($urandom);
    return time_t'($urandom_range(hi, lo));
  endfunction

  // Durations on and just beside the current thresholds, plus the extremes.
  function automatic time_t edge_time();
    case ($urandom_range(0, 10))
      0:       return sb.guide_min;
      1:       return sb.guide_min - 1'b1;
      2:       return sb.guide_max;
      3:       return sb.guide_max + 1'b1;
      4:       return sb.one_min;
      5:       return sb.one_min - 1'b1;
      6:       return sb.zero_min;
      7:       return sb.zero_min - 1'b1;
      8:       return '0;
      9:       return '1;
      default: return time_t'($urandom);
    endcase
  endfunction

  // Guide then one pulse per bit, with the odd filler tick, stray guide or
  // out-of-range pulse mixed in.
  task automatic send_frame();
    int n;
    send_beat(1'b0, 1'b1, in_span(sb.guide_min, sb.guide_max));
    for (n = 0; n < WORD_BITS; n++) begin
      if ($urandom_range(0, 3) == 0)
        send_beat($urandom_range(0, 4) == 0, 1'b0, time_t'($urandom));
      case ($urandom_range(0, 9))
        0:          send_beat(1'b0, 1'b1, in_span(sb.guide_min, sb.guide_max));
        1:          send_beat(1'b0, 1'b1, edge_time());
        2, 3, 4, 5: send_beat(1'b0, 1'b1, in_span(sb.one_min, int'(sb.guide_min) - 1));
        default:    send_beat(1'b0, 1'b1, in_span(sb.zero_min, int'(sb.one_min) - 1));
      endcase
    end
  endtask

  // Line held high for a random run that may cross the limit (bounded for big limits),
  // with captures arriving while the signal is lost.
  task automatic send_silence();
    int len;
    int n;
    len = (sb.silence_limit > 250) ? $urandom_range(1, 60)
                                   : $urandom_range(1, int'(sb.silence_limit) + 4);
    for (n = 0; n < len; n++)
      send_beat(1'b1, $urandom_range(0, 3) == 0, edge_time());
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = beats + count;
    while (beats < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      send_frame();
      else if (pick < 80) send_silence();
      else                send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    edge_time());
    end
  endtask

  task automatic run_directed();
    // full frame at reset thresholds: one, zero, out-of-range, top of one span
    send_beat(1'b0, 1'b1, 16'd1000);
    send_beat(1'b0, 1'b1, 16'd700);
    send_beat(1'b0, 1'b1, 16'd300);
    send_beat(1'b0, 1'b1, 16'd50);
    send_beat(1'b0, 1'b1, 16'd899);
    // guide at both bounds, the second one mid-frame
    send_beat(1'b0, 1'b1, 16'd900);
    send_beat(1'b0, 1'b1, 16'd500);
    send_beat(1'b0, 1'b1, 16'd1100);
    send_beat(1'b0, 1'b1, 16'd100);
    send_beat(1'b0, 1'b1, 16'd499);
    send_beat(1'b0, 1'b1, 16'hFFFF);
    // non-guide pulses with no guide seen are dropped
    send_beat(1'b0, 1'b1, 16'd0);
    send_beat(1'b0, 1'b1, 16'd1101);
    // ticks mostly without capture: line high for a few ticks (one capturing a guide), then low again
    send_beat(1'b0, 1'b0, 16'hFFFF);
    send_beat(1'b1, 1'b0, 16'h0000);
    send_beat(1'b1, 1'b1, 16'd950);
    send_beat(1'b1, 1'b0, 16'h5555);
    send_beat(1'b0, 1'b0, 16'hAAAA);
  endtask

  initial begin : stimulus
    int zs;
    int os;
    int gs;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_GUIDE_MIN;
    cfg_wdata  = '0;
    beats      = 0;
    burst_left = 0;
    settings   = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds, including some long silences past the default limit
    run_directed();
    run_random(280);

    // widened bit spans, short limit, cap just above it
    apply_setting(2000, 3000, 1000, 10, 12, 20);
    run_random(300);

    // everything is a guide; counter reloads every idle tick and wraps to zero
    apply_setting(0, 65535, 0, 0, 16383, 0);
    run_random(150);

    // empty guide span and a zero limit: signal lost on every tick
    apply_setting(65535, 0, 0, 65535, 0, 16383);
    run_random(100);

    // overlapping spans with an empty zero span; cap below the limit
    apply_setting(300, 300, 200, 250, 5, 3);
    run_random(300);

    // random ordered thresholds and a small random limit and cap
    zs = $urandom_range(0, 20000);
    os = zs + $urandom_range(1, 15000);
    gs = os + $urandom_range(1, 15000);
    apply_setting(gs, gs + $urandom_range(0, 10000), os, zs,
                  $urandom_range(2, 40), $urandom_range(0, 60));
    run_random(400);

    // guide span, silence limit and cap at the top of their ranges
    apply_setting(65535, 65535, 1, 0, 16383, 16383);
    run_random(330);

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d poll beats over reset and %0d threshold sets, %0d results checked",
             beats, settings, sb.checked);
    $display("decoded %0d nibbles from %0d guides; %0d beats reported lost signal",
             sb.nibbles, sb.guides, sb.lost_codes);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
